// File: sv/satpc_pkg.sv
// ----------------------------------------------------------------------------
// satpc_pkg
// Shared types and constants for the separating-axis collision core.
// ----------------------------------------------------------------------------
package satpc_pkg;

  localparam int MaxSidesDefault = 16;
  localparam int CoordW          = 16;
  localparam int UnitQ14         = 16384;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD_A = 2'd1,
    OP_ADD_B = 2'd2,
    OP_TEST  = 2'd3
  } op_t;

  // Shared divide request and response between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [51:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [51:0] quo;
  } div_rsp_t;

endpackage

// File: sv/satpc_sqrt.sv
// ----------------------------------------------------------------------------
// satpc_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module satpc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        done,
  output logic [30:0] root
);

  logic [61:0] rem;
  logic [61:0] res;
  logic [61:0] bitv;
  logic        busy;
  logic [61:0] trial;

  assign trial = res + bitv;
  assign root  = res[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 62'd1 << 60;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

endmodule

// File: sv/satpc_div.sv
// ----------------------------------------------------------------------------
// satpc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module satpc_div (
  input  logic                clk,
  input  logic                rst,
  input  satpc_pkg::div_req_t req,
  output satpc_pkg::div_rsp_t rsp
);

  logic [51:0] quo;
  logic [34:0] rem;
  logic [33:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_q;
  logic [34:0] shifted;

  assign shifted = {rem[33:0], quo[51]};
  assign rsp     = {done_q, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= 6'd52;
      end else if (busy) begin
        if (shifted >= {1'b0, den}) begin
          rem <= shifted - {1'b0, den};
          quo <= {quo[50:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[50:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/sat_polygon_collision_core.sv
// ----------------------------------------------------------------------------
// sat_polygon_collision_core
// Separating-axis test of two convex polygons with a shared sqrt, divider
// and multiplier under one sequencer.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                     | tuser
// s_axis  | in  | start_x/y, end_x/y, pos_a_x/y, pos_b_x/y  | op
// m_axis  | out | mtv_x, mtv_y                              | collides, status
//
// Clear and add transfers may follow back to back.
// A test runs per axis: fetch the side and square the normal, a square
// root, two divides, then the projections of every stored side (one shared
// multiplier, two products a side) and an evaluation; a zero-length side
// skips the divides and the projections.
// Reset clears the sequencer and the side counts; side stores have none.
// The result waits in the output register; a stall there holds the block.
// ----------------------------------------------------------------------------
module sat_polygon_collision_core #(
  parameter int MAX_SIDES = satpc_pkg::MaxSidesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, end_x, end_y, pos_a_x, pos_a_y, pos_b_x, pos_b_y
  // (16 each)
  input  logic [127:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mtv_x[15:0], mtv_y[31:16]
  output logic [31:0]  m_axis_tdata,
  // collides[0], status[1]
  output logic [1:0]   m_axis_tuser
);

  localparam int IdxW = $clog2(MAX_SIDES);
  localparam int CntW = $clog2(MAX_SIDES + 1);
  localparam int AxW  = CntW + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FETCH = 12'b000000000010,
    S_RAW   = 12'b000000000100,
    S_SQ    = 12'b000000001000,
    S_SQRT  = 12'b000000010000,
    S_DIVX  = 12'b000000100000,
    S_DIVY  = 12'b000001000000,
    S_PRJRD = 12'b000010000000,
    S_PRJX  = 12'b000100000000,
    S_PRJY  = 12'b001000000000,
    S_EVAL  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  // side stores: {sx, sy, ex, ey}
  logic [63:0] mem_a [MAX_SIDES];
  logic [63:0] mem_b [MAX_SIDES];
  logic [63:0] rd_a, rd_b;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] count_a, count_b;

  logic [1:0]  op;
  logic [15:0] in_sx, in_sy, in_ex, in_ey;
  assign op    = s_axis_tuser;
  assign in_sx = s_axis_tdata[15:0];
  assign in_sy = s_axis_tdata[31:16];
  assign in_ex = s_axis_tdata[47:32];
  assign in_ey = s_axis_tdata[63:48];

  logic signed [15:0] pax, pay, pbx, pby;
  logic [AxW-1:0] axis_k;
  logic [CntW-1:0] prj_i;
  logic prj_b;
  logic signed [16:0] ax, ay;
  logic [33:0] sq;
  logic [33:0] sq_sum;
  logic [30:0] root;
  logic [30:0] root_cur;
  logic signed [15:0] nx, ny;
  logic signed [33:0] prod_x;
  logic signed [34:0] dot;
  logic signed [34:0] mina, maxa, minb, maxb, best_ov;
  logic have, first;
  logic res_coll, res_status;
  logic signed [15:0] res_mx, res_my;

  logic sq_start, sq_done;
  logic [30:0] sq_root;
  satpc_pkg::div_req_t dreq;
  satpc_pkg::div_rsp_t drsp;

  // squared length of the raw normal, taken by the sqrt as it starts
  assign sq_sum = 34'(ax * ax) + 34'(ay * ay);

  satpc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start),
    .radicand({sq_sum, 28'd0}), .done(sq_done), .root(sq_root)
  );

  satpc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // the x divide starts as the root arrives, before it is registered
  assign root_cur = (state == S_SQRT) ? sq_root : root;

  logic [16:0] mag_sel;
  assign mag_sel = (state == S_SQRT) ? (ax[16] ? -ax : ax) : (ay[16] ? -ay : ay);
  assign dreq.num = {7'd0, mag_sel, 28'd0} + {22'd0, root_cur[30:1]};
  assign dreq.den = {3'd0, root_cur};

  logic [15:0] qsat;
  assign qsat = (drsp.quo > 52'(satpc_pkg::UnitQ14)) ? 16'(satpc_pkg::UnitQ14)
                                                     : drsp.quo[15:0];

  // shared multiplier: 17-bit point coordinate by Q1.14 component
  logic [63:0] rd_cur;
  logic [63:0] rd_axis;
  logic signed [16:0] pt;
  logic signed [15:0] mcoef;
  logic signed [33:0] prod;
  assign rd_cur  = prj_b ? rd_b : rd_a;
  assign rd_axis = axis_in_b ? rd_b : rd_a;
  assign pt = (state == S_PRJX)
            ? (17'(signed'(rd_cur[63:48])) + 17'(prj_b ? pbx : pax))
            : (17'(signed'(rd_cur[47:32])) + 17'(prj_b ? pby : pay));
  assign mcoef = (state == S_PRJX) ? nx : ny;
  assign prod  = 34'(pt) * 34'(mcoef);
  assign dot   = 35'(prod_x) + 35'(prod);

  logic signed [34:0] lo, hi, ov;
  assign lo = (mina > minb) ? mina : minb;
  assign hi = (maxa < maxb) ? maxa : maxb;
  assign ov = hi - lo;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {res_my, res_mx};
  assign m_axis_tuser  = {res_status, res_coll};
  assign sq_start = (state == S_SQ);
  // no divide for a zero-length side
  assign dreq.start = (state == S_SQRT && sq_done && sq != '0)
                   || (state == S_DIVX && drsp.done);

  always_ff @(posedge clk) begin
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
    if (state == S_IDLE && s_axis_tvalid) begin
      if (op == satpc_pkg::OP_ADD_A && count_a < CntW'(MAX_SIDES))
        mem_a[count_a[IdxW-1:0]] <= {in_sx, in_sy, in_ex, in_ey};
      if (op == satpc_pkg::OP_ADD_B && count_b < CntW'(MAX_SIDES))
        mem_b[count_b[IdxW-1:0]] <= {in_sx, in_sy, in_ex, in_ey};
    end
  end

  logic axis_in_b;
  assign axis_in_b = (axis_k >= AxW'(count_a));
  always_comb begin
    rd_addr = prj_i[IdxW-1:0];
    if (state == S_IDLE || state == S_FETCH || state == S_EVAL)
      rd_addr = axis_in_b ? IdxW'(axis_k - AxW'(count_a)) : axis_k[IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_a <= '0;
      count_b <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (satpc_pkg::op_t'(op))
              satpc_pkg::OP_CLEAR: begin
                count_a <= '0;
                count_b <= '0;
              end
              satpc_pkg::OP_ADD_A:
                if (count_a < CntW'(MAX_SIDES)) count_a <= count_a + 1'b1;
              satpc_pkg::OP_ADD_B:
                if (count_b < CntW'(MAX_SIDES)) count_b <= count_b + 1'b1;
              satpc_pkg::OP_TEST: begin
                pax <= s_axis_tdata[79:64];
                pay <= s_axis_tdata[95:80];
                pbx <= s_axis_tdata[111:96];
                pby <= s_axis_tdata[127:112];
                res_coll   <= 1'b0;
                res_status <= 1'b0;
                res_mx     <= '0;
                res_my     <= '0;
                have       <= 1'b0;
                axis_k     <= '0;
                if (count_a == '0 || count_b == '0) begin
                  res_status <= 1'b1;
                  state      <= S_OUT;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_FETCH: state <= S_RAW;  // wait for the registered read
        S_RAW: begin
          // raw normal (ey - sy, sx - ex)
          ax <= 17'(signed'(rd_axis[15:0])) - 17'(signed'(rd_axis[47:32]));
          ay <= 17'(signed'(rd_axis[63:48])) - 17'(signed'(rd_axis[31:16]));
          state <= S_SQ;
        end
        S_SQ: begin
          // the sqrt starts on this edge from the same sum
          sq    <= sq_sum;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            root <= sq_root;
            if (sq == '0) state <= S_EVAL;
            else state <= S_DIVX;
          end
        end
        S_DIVX: if (drsp.done) begin
          nx    <= ax[16] ? -signed'(qsat) : signed'(qsat);
          state <= S_DIVY;
        end
        S_DIVY: if (drsp.done) begin
          ny    <= ay[16] ? -signed'(qsat) : signed'(qsat);
          prj_i <= '0;
          prj_b <= 1'b0;
          first <= 1'b1;
          state <= S_PRJRD;
        end
        S_PRJRD: state <= S_PRJX;
        S_PRJX: begin
          prod_x <= prod;
          state  <= S_PRJY;
        end
        S_PRJY: begin
          if (!prj_b) begin
            if (first || dot < mina) mina <= dot;
            if (first || dot > maxa) maxa <= dot;
          end else begin
            if (first || dot < minb) minb <= dot;
            if (first || dot > maxb) maxb <= dot;
          end
          first <= 1'b0;
          state <= S_PRJRD;
          prj_i <= prj_i + 1'b1;
          if (!prj_b && prj_i == count_a - 1'b1) begin
            prj_b <= 1'b1;
            prj_i <= '0;
            first <= 1'b1;
          end else if (prj_b && prj_i == count_b - 1'b1) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          // a zero-length side arrives here with sq zero and is skipped
          if (sq != '0 && (maxa < minb || maxb < mina)) begin
            // separated: drop any axis kept so far
            res_coll <= 1'b0;
            res_mx   <= '0;
            res_my   <= '0;
            state    <= S_OUT;
          end else begin
            if (sq != '0 && (!have || ov < best_ov)) begin
              have    <= 1'b1;
              best_ov <= ov;
              res_mx  <= nx;
              res_my  <= ny;
            end
            if (axis_k == AxW'(count_a) + AxW'(count_b) - 1'b1) begin
              res_coll <= 1'b1;
              state    <= S_OUT;
            end else begin
              axis_k <= axis_k + 1'b1;
              state  <= S_FETCH;
            end
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/satpc_checker.sv
// ----------------------------------------------------------------------------
// satpc_checker
// Port-level checks of the collision core, bound to the top level.
// ----------------------------------------------------------------------------
module satpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // a separated or empty test reports a zero axis
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("non-zero MTV without collision");

  // empty-shape status never comes with a collision
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("status and collides both set");

endmodule

bind sat_polygon_collision_core satpc_checker u_satpc_checker (.*);
